>>> sv/assert_macros.svh
// Assertion macros used by the checker file of the steering servo.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, suppressed while the reset is high
`define CPSS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset
`define CPSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cpss_pkg.sv
// Types, constants and microcode for the cascaded PD steering servo.
// Depends on nothing; the design, checker and testbench files refer to it by scoped names.
package cpss_pkg;

   // Q8.8 operands, Q16.16 products
   localparam int FRAC_W      = 16;
   localparam int STEER_LIMIT = 82;
   localparam int ARRIVE_STEP = 1843;    // 7.2 in Q8.8
   localparam int MEET_STEP   = 1690;    // 6.6 in Q8.8
   // floor(a / 25) = (a * RECIP_25) >> RECIP_SHIFT, exact for a < 2**20
   localparam int RECIP_25    = 1342178;
   localparam int RECIP_SHIFT = 25;
   localparam int GQ_W        = 15;      // quotient of the gyro scaling

   localparam int MUL_A_W = 21;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
   localparam int ACC_W   = 36;
   localparam int Q_W     = ACC_W - FRAC_W;
   localparam int ERR_W   = 18;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER_KD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KP       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_KD       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SERVO_CENTRE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TWO_CAR_MODE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CASCADE_ENABLE = 3'd6;

   typedef struct packed {
      logic signed [15:0] offset_sample;
      logic               offset_valid;
      logic               meeting_enable;
      logic               at_meeting_place;
      logic               meeting_arrived;
      logic               backing_out;
      logic               end_line_seen;
      logic               meeting_zone;
      logic signed [15:0] left_count;
      logic signed [15:0] right_count;
      logic signed [15:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic        [15:0] servo_pwm;
      logic signed [7:0]  steer_command;
   } rsp_type;

   typedef struct packed {
      logic [15:0] outer_kp;
      logic [15:0] outer_kd;
      logic [15:0] inner_kp;
      logic [15:0] inner_kd;
      logic [15:0] servo_centre;
      logic        two_car_mode;
      logic        cascade_enable;
   } cfg_type;

   // Microcode fields
   typedef enum logic [2:0] {A_KP, A_KD, A_IKP, A_IKD, A_RECIP} a_sel_type;
   typedef enum logic [2:0] {B_OFF, B_DOUT, B_GYRO, B_ERR, B_DERR} b_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [2:0] {
      OP_NONE, OP_ADJUST, OP_STEER, OP_ERROR, OP_CMD, OP_FINISH
   } op_type;
   typedef enum logic [1:0] {J_NONE, J_NOMODE, J_NOCASC} jmp_type;

   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      logic              mul_en;
      acc_op_type        acc_op;
      op_type            op;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   // Conditions the datapath hands back to the sequencer
   typedef struct packed {
      logic nomode;
      logic nocasc;
   } status_type;

   localparam logic [STEP_W-1:0] STEP_STEER  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FINISH = 4'd11;

   localparam ctrl_type CTRL_IDLE = '{
      a_sel: A_KP, b_sel: B_OFF, mul_en: 1'b0, acc_op: ACC_HOLD,
      op: OP_NONE, jmp: J_NONE, target: '0
   };

   // Control store: one word per step
   function automatic ctrl_type mc_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      w = CTRL_IDLE;
      case (step)
         4'd0: begin                       // apply arrival or meeting nudge
            w.op     = OP_ADJUST;
            w.jmp    = J_NOMODE;
            w.target = STEP_STEER;
         end
         4'd1: begin                       // kp * offset
            w.a_sel  = A_KP;
            w.b_sel  = B_OFF;
            w.mul_en = 1'b1;
         end
         4'd2: begin                       // kd * derivative
            w.a_sel  = A_KD;
            w.b_sel  = B_DOUT;
            w.mul_en = 1'b1;
            w.acc_op = ACC_LOAD;
         end
         4'd3: begin
            w.acc_op = ACC_ADD;
         end
         4'd4: begin                       // outer command, history shift
            w.op     = OP_STEER;
            w.jmp    = J_NOCASC;
            w.target = STEP_FINISH;
         end
         4'd5: begin                       // gyro scaling by 16/25
            w.a_sel  = A_RECIP;
            w.b_sel  = B_GYRO;
            w.mul_en = 1'b1;
         end
         4'd6: begin
            w.op = OP_ERROR;
         end
         4'd7: begin
            w.a_sel  = A_IKP;
            w.b_sel  = B_ERR;
            w.mul_en = 1'b1;
         end
         4'd8: begin
            w.a_sel  = A_IKD;
            w.b_sel  = B_DERR;
            w.mul_en = 1'b1;
            w.acc_op = ACC_LOAD;
         end
         4'd9: begin
            w.acc_op = ACC_ADD;
         end
         4'd10: begin
            w.op = OP_CMD;
         end
         4'd11: begin
            w.op = OP_FINISH;
         end
         default: begin
            w.op = OP_FINISH;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/cascaded_pd_steering_servo.sv
// Top level of the cascaded PD steering servo: ports, configuration registers,
// result register. Depends on cpss_pkg, cpss_seq and cpss_dp.
//
// One control tick is one transfer on req_*: offset, meeting flags, wheel pulse
// signs and gyro rate. The block answers with one transfer on rsp_* carrying the
// servo PWM value and the clamped, possibly inverted outer steering command.
// Work runs as a short microprogram over a single shared 22x21 multiplier and
// one accumulator, so ticks are processed one at a time. A tick to which no
// mode applies skips the outer PD multiplies, and the inner loop steps run
// only with cascade_enable set. The next tick is taken in the cycle after the
// result is loaded. A finished result waits in the output register while the
// next tick is accepted. Configuration is a plain write port (index 0
// outer_kp ... 6 cascade_enable, others dropped) and should only be written
// while no tick is in flight.
module cascaded_pd_steering_servo (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  cpss_pkg::req_type                 req_data,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cpss_pkg::rsp_type                 rsp_data,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [cpss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cpss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   cpss_pkg::cfg_type     cfg_ff, cfg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cpss_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   cpss_pkg::ctrl_type    ctrl;
   cpss_pkg::status_type  status;
   logic                  start, emit, busy, out_free;
   logic signed [7:0]     steer, cmd;

   // Take a tick only while the sequencer is parked
   assign start     = req_valid && !busy;
   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration registers; drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cpss_pkg::REG_OUTER_KP:       cfg_in.outer_kp       = csr_wdata;
            cpss_pkg::REG_OUTER_KD:       cfg_in.outer_kd       = csr_wdata;
            cpss_pkg::REG_INNER_KP:       cfg_in.inner_kp       = csr_wdata;
            cpss_pkg::REG_INNER_KD:       cfg_in.inner_kd       = csr_wdata;
            cpss_pkg::REG_SERVO_CENTRE:   cfg_in.servo_centre   = csr_wdata;
            cpss_pkg::REG_TWO_CAR_MODE:   cfg_in.two_car_mode   = csr_wdata[0];
            cpss_pkg::REG_CASCADE_ENABLE: cfg_in.cascade_enable = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.outer_kp       <= 16'd2074;
         cfg_ff.outer_kd       <= 16'd6400;
         cfg_ff.inner_kp       <= 16'd154;
         cfg_ff.inner_kd       <= 16'd205;
         cfg_ff.servo_centre   <= 16'd1500;
         cfg_ff.two_car_mode   <= 1'b0;
         cfg_ff.cascade_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpss_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .status   (status),
      .ctrl     (ctrl),
      .emit     (emit),
      .busy     (busy)
   );

   cpss_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req    (req_data),
      .cfg    (cfg_ff),
      .ctrl   (ctrl),
      .status (status),
      .steer  (steer),
      .cmd    (cmd)
   );

   // Result register: load on the final step, hold while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.servo_pwm       = cfg_ff.servo_centre - {{8{cmd[7]}}, cmd};
         rsp_data_in.steer_command   = steer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/cpss_seq.sv
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on cpss_pkg.
module cpss_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   input  cpss_pkg::status_type  status,
   output cpss_pkg::ctrl_type    ctrl,
   output logic                  emit,
   output logic                  busy
);

   logic                          busy_ff, busy_in;
   logic [cpss_pkg::STEP_W-1:0]   step_ff, step_in;
   cpss_pkg::ctrl_type            word;
   logic                          taken;

   assign word = cpss_pkg::mc_rom(step_ff);

   always_comb begin
      case (word.jmp)
         cpss_pkg::J_NOMODE: taken = status.nomode;
         cpss_pkg::J_NOCASC: taken = status.nocasc;
         default:            taken = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (word.op == cpss_pkg::OP_FINISH) begin
         // hold on the last step until the result register frees up
         if (out_free) begin
            busy_in = 1'b0;
         end
      end else begin
         step_in = taken ? word.target : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl = busy_ff ? word : cpss_pkg::CTRL_IDLE;
   assign emit = busy_ff && (word.op == cpss_pkg::OP_FINISH) && out_free;
   assign busy = busy_ff;

endmodule

>>> sv/cpss_dp.sv
// Datapath: offset history, shared multiplier, accumulator, clamps.
// Depends on cpss_pkg; driven by the control word of cpss_seq.
module cpss_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  cpss_pkg::req_type         req,
   input  cpss_pkg::cfg_type         cfg,
   input  cpss_pkg::ctrl_type        ctrl,
   output cpss_pkg::status_type      status,
   output logic signed [7:0]         steer,
   output logic signed [7:0]         cmd
);

   localparam int ACC_W  = cpss_pkg::ACC_W;
   localparam int Q_W    = cpss_pkg::Q_W;
   localparam int FRAC_W = cpss_pkg::FRAC_W;
   localparam int ERR_W  = cpss_pkg::ERR_W;
   localparam int GQ_W   = cpss_pkg::GQ_W;
   localparam logic signed [Q_W-1:0] QMAX = Q_W'(cpss_pkg::STEER_LIMIT);
   localparam logic signed [Q_W-1:0] QMIN = -QMAX;

   // Q16.16 sum to integer toward zero, then clamp to the steering limit
   function automatic logic signed [7:0] pd_clamp(input logic signed [ACC_W-1:0] a);
      logic signed [Q_W-1:0] q;
      logic signed [7:0]     r;
      q = $signed(a[ACC_W-1:FRAC_W]);
      if (a[ACC_W-1] && (a[FRAC_W-1:0] != '0)) begin
         q = q + Q_W'(1);
      end
      if (q > QMAX) begin
         r = QMAX[7:0];
      end else if (q < QMIN) begin
         r = QMIN[7:0];
      end else begin
         r = q[7:0];
      end
      return r;
   endfunction

   // Latched item flags
   logic                      normal_ff, nomode_ff, arrive_ff, meet_ff, invert_ff;
   logic                      gyro_neg_ff;
   logic [15:0]               gyro_abs_ff;
   logic                      normal_in, nomode_in, arrive_in, meet_in, invert_in;
   logic                      both_rev;

   // State with reset
   logic signed [15:0]        off_ff, off_in, prev_ff, prev_in, prev2_ff, prev2_in;
   logic signed [7:0]         held_ff, held_in;
   logic signed [ERR_W-1:0]   ilast_ff, ilast_in;

   // Working registers
   logic signed [cpss_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]            acc_ff, acc_in;
   logic signed [7:0]                  steer_ff, steer_in, cmd_ff, cmd_in;
   logic signed [ERR_W-1:0]            e_ff, e_in;

   logic [cpss_pkg::MUL_A_W-1:0]        mul_a;
   logic signed [cpss_pkg::MUL_B_W-1:0] mul_b;
   logic signed [16:0]                  d_outer;
   logic signed [ERR_W:0]               d_inner;
   logic signed [16:0]                  sum_up, sum_dn;
   logic signed [7:0]                   steer_base;
   logic [GQ_W-1:0]                     gq;
   logic signed [ERR_W-1:0]             g_signed;

   // Decode the tick's mode when the item is taken
   always_comb begin
      both_rev  = req.left_count[15] && req.right_count[15];
      normal_in = !req.meeting_enable && !req.at_meeting_place;
      arrive_in = !normal_in && req.at_meeting_place && req.meeting_arrived;
      meet_in   = !normal_in && !arrive_in && req.meeting_enable;
      nomode_in = !normal_in && !arrive_in && !meet_in;
      invert_in = req.backing_out || (both_rev && req.end_line_seen && cfg.two_car_mode)
                  || (req.meeting_zone && both_rev);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         normal_ff   <= normal_in;
         arrive_ff   <= arrive_in;
         meet_ff     <= meet_in;
         nomode_ff   <= nomode_in;
         invert_ff   <= invert_in;
         gyro_neg_ff <= req.gyro_rate[15];
         gyro_abs_ff <= req.gyro_rate[15] ? 16'(-req.gyro_rate) : req.gyro_rate;
      end
   end

   // Multiplier operands
   always_comb begin
      d_outer = {off_ff[15], off_ff} - (normal_ff ? {prev2_ff[15], prev2_ff}
                                                  : {prev_ff[15], prev_ff});
      d_inner = {e_ff[ERR_W-1], e_ff} - {ilast_ff[ERR_W-1], ilast_ff};
      case (ctrl.a_sel)
         cpss_pkg::A_KP:    mul_a = cpss_pkg::MUL_A_W'(cfg.outer_kp);
         cpss_pkg::A_KD:    mul_a = cpss_pkg::MUL_A_W'(cfg.outer_kd);
         cpss_pkg::A_IKP:   mul_a = cpss_pkg::MUL_A_W'(cfg.inner_kp);
         cpss_pkg::A_IKD:   mul_a = cpss_pkg::MUL_A_W'(cfg.inner_kd);
         cpss_pkg::A_RECIP: mul_a = cpss_pkg::MUL_A_W'(cpss_pkg::RECIP_25);
         default:           mul_a = '0;
      endcase
      case (ctrl.b_sel)
         cpss_pkg::B_OFF:  mul_b = cpss_pkg::MUL_B_W'(off_ff);
         cpss_pkg::B_DOUT: mul_b = cpss_pkg::MUL_B_W'(d_outer);
         cpss_pkg::B_GYRO: mul_b = $signed({1'b0, gyro_abs_ff, 4'b0000});
         cpss_pkg::B_ERR:  mul_b = cpss_pkg::MUL_B_W'(e_ff);
         cpss_pkg::B_DERR: mul_b = cpss_pkg::MUL_B_W'(d_inner);
         default:          mul_b = '0;
      endcase
      prod_in = ctrl.mul_en ? $signed({1'b0, mul_a}) * mul_b : prod_ff;
   end

   always_comb begin
      case (ctrl.acc_op)
         cpss_pkg::ACC_LOAD: acc_in = $signed(prod_ff[ACC_W-1:0]);
         cpss_pkg::ACC_ADD:  acc_in = acc_ff + $signed(prod_ff[ACC_W-1:0]);
         default:            acc_in = acc_ff;
      endcase
   end

   // Step operations
   always_comb begin
      off_in   = off_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      held_in  = held_ff;
      ilast_in = ilast_ff;
      steer_in = steer_ff;
      cmd_in   = cmd_ff;
      e_in     = e_ff;

      sum_up     = {off_ff[15], off_ff} + 17'(cpss_pkg::ARRIVE_STEP);
      sum_dn     = {off_ff[15], off_ff} - 17'(cpss_pkg::MEET_STEP);
      steer_base = nomode_ff ? held_ff : pd_clamp(acc_ff);
      gq         = prod_ff[cpss_pkg::RECIP_SHIFT +: GQ_W];
      g_signed   = gyro_neg_ff ? -ERR_W'(gq) : ERR_W'(gq);

      if (start && req.offset_valid) begin
         off_in = req.offset_sample;
      end

      case (ctrl.op)
         cpss_pkg::OP_ADJUST: begin
            // nudge with saturation to the Q8.8 range
            if (arrive_ff) begin
               off_in = (sum_up[16] != sum_up[15]) ? (sum_up[16] ? 16'sh8000 : 16'sh7fff)
                                                   : sum_up[15:0];
            end else if (meet_ff) begin
               off_in = (sum_dn[16] != sum_dn[15]) ? (sum_dn[16] ? 16'sh8000 : 16'sh7fff)
                                                   : sum_dn[15:0];
            end
         end
         cpss_pkg::OP_STEER: begin
            steer_in = invert_ff ? -steer_base : steer_base;
            held_in  = steer_in;
            cmd_in   = steer_in;
            prev2_in = prev_ff;
            prev_in  = off_ff;
         end
         cpss_pkg::OP_ERROR: begin
            e_in = $signed({steer_ff[7], steer_ff[7], steer_ff, 8'h00}) + g_signed;
         end
         cpss_pkg::OP_CMD: begin
            cmd_in   = pd_clamp(acc_ff);
            ilast_in = e_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
         held_ff  <= '0;
         ilast_ff <= '0;
      end else begin
         off_ff   <= off_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         held_ff  <= held_in;
         ilast_ff <= ilast_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      steer_ff <= steer_in;
      cmd_ff   <= cmd_in;
      e_ff     <= e_in;
   end

   assign status.nomode = nomode_ff;
   assign status.nocasc = !cfg.cascade_enable;
   assign steer = steer_ff;
   assign cmd   = cmd_ff;

endmodule

>>> sv/cpss_chk.sv
// Port-level checker for the steering servo, bound to the top level.
// Depends on cpss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpss_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input cpss_pkg::req_type  req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input cpss_pkg::rsp_type  rsp_data
);

   `CPSS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "stalled result changed")

   `CPSS_ASSERT(a_steer_range, clock, reset, rsp_valid |-> ((rsp_data.steer_command <= 8'sd82) && (rsp_data.steer_command >= -8'sd82)), "steer command outside limit")

   `CPSS_ASSERT(a_one_at_a_time, clock, reset, (req_valid && !req_stall) |=> req_stall, "tick taken while another in flight")

   `CPSS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && !req_stall), "not idle after reset")

endmodule

bind cascaded_pd_steering_servo cpss_chk u_chk (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded PD steering servo: a directed tick table,
// then random ticks over several register settings, scored against the table's expected results or a local model.
// Depends on cpss_pkg and cascaded_pd_steering_servo.
module tb_top;

   // Flag groups for the directed table: {meeting_enable, at_meeting_place,
   // meeting_arrived, backing_out, end_line_seen, meeting_zone}
   localparam bit [5:0] NO_FLAGS  = 6'b000000;
   localparam bit [5:0] F_MEET    = 6'b100000;
   localparam bit [5:0] F_PLACE   = 6'b010000;
   localparam bit [5:0] F_ARRIVED = 6'b001000;
   localparam bit [5:0] F_BACK    = 6'b000100;
   localparam bit [5:0] F_ENDLINE = 6'b000010;
   localparam bit [5:0] F_ZONE    = 6'b000001;

   // Index with no register behind it; writes there must change nothing
   localparam logic [cpss_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   localparam cpss_pkg::rsp_type NO_RSP      = '0;
   localparam int                HOLD_CYCLES = 300;   // long output hold-off
   localparam int                TAIL_CYCLES = 16;    // a little over the slowest tick

   typedef struct {
      cpss_pkg::req_type tick;
      bit                typed;   // expected result written into the table
      cpss_pkg::rsp_type rsp;
   } tick_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   cpss_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   cpss_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en;
   logic [cpss_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cpss_pkg::CSR_DATA_W-1:0] csr_wdata;

   cascaded_pd_steering_servo i_dut (.*);

   // Local copy of the register file and of the controller state
   cpss_pkg::cfg_type model_cfg;
   int      off_now;
   int      off_prev;
   int      off_prev2;
   int      held_steer;
   int      rate_err_last;

   // Results still owed by the block, oldest first
   cpss_pkg::rsp_type awaited_outputs [$];

   int fault_count      = 0;
   int mismatch_reports = 0;
   int ticks_sent       = 0;
   int outputs_checked  = 0;
   int settings_seen    = 0;
   int burst_left       = 0;
   bit long_hold_due    = 1'b0;

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generous fixed limit: the slowest legal run needs well under a tenth of this
   initial begin
      #3_000_000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic int clamp_steer(longint v);
      if (v > cpss_pkg::STEER_LIMIT) return cpss_pkg::STEER_LIMIT;
      if (v < -cpss_pkg::STEER_LIMIT) return -cpss_pkg::STEER_LIMIT;
      return int'(v);
   endfunction

   function automatic int sat_q88(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Q8.8 gains times Q8.8 operands, summed in Q16.16, cut toward zero
   function automatic longint pd_sum(logic [15:0] kp, logic [15:0] kd, longint e, longint d);
      longint kp_l;
      longint kd_l;
      kp_l = kp;
      kd_l = kd;
      return (kp_l * e + kd_l * d) / 65536;
   endfunction

   // Advance the local controller by one tick and return the result it owes
   function automatic cpss_pkg::rsp_type steer_tick(cpss_pkg::req_type t);
      int                steer;
      int                cmd;
      int                rate_q;
      int                err;
      int                pwm;
      bit                both_rev;
      bit                flip;
      cpss_pkg::rsp_type r;
      both_rev = ($signed(t.left_count) < 0) && ($signed(t.right_count) < 0);
      if (t.offset_valid) off_now = $signed(t.offset_sample);
      if (!t.meeting_enable && !t.at_meeting_place) begin
         // plain PD: derivative spans two ticks
         steer = clamp_steer(pd_sum(model_cfg.outer_kp, model_cfg.outer_kd, off_now,
                                    longint'(off_now) - off_prev2));
      end else if (t.at_meeting_place && t.meeting_arrived) begin
         off_now = sat_q88(off_now + cpss_pkg::ARRIVE_STEP);
         steer = clamp_steer(pd_sum(model_cfg.outer_kp, model_cfg.outer_kd, off_now,
                                    longint'(off_now) - off_prev));
      end else if (t.meeting_enable) begin
         off_now = sat_q88(off_now - cpss_pkg::MEET_STEP);
         steer = clamp_steer(pd_sum(model_cfg.outer_kp, model_cfg.outer_kd, off_now,
                                    longint'(off_now) - off_prev));
      end else begin
         steer = held_steer;
      end
      flip = t.backing_out || (both_rev && t.end_line_seen && model_cfg.two_car_mode) ||
             (both_rev && t.meeting_zone);
      if (flip) steer = -steer;
      held_steer = steer;
      off_prev2  = off_prev;
      off_prev   = off_now;
      cmd = steer;
      if (model_cfg.cascade_enable) begin
         rate_q = $signed(t.gyro_rate);
         rate_q = rate_q * 256 / 400;
         err    = steer * 256 + rate_q;
         cmd    = clamp_steer(pd_sum(model_cfg.inner_kp, model_cfg.inner_kd, err,
                                     longint'(err) - rate_err_last));
         rate_err_last = err;
      end
      pwm = int'(model_cfg.servo_centre) - cmd;
      r.servo_pwm     = pwm[15:0];
      r.steer_command = steer[7:0];
      return r;
   endfunction

   function automatic void apply_reg(logic [cpss_pkg::CSR_IDX_W-1:0] idx,
                                     logic [cpss_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         cpss_pkg::REG_OUTER_KP:       model_cfg.outer_kp       = val;
         cpss_pkg::REG_OUTER_KD:       model_cfg.outer_kd       = val;
         cpss_pkg::REG_INNER_KP:       model_cfg.inner_kp       = val;
         cpss_pkg::REG_INNER_KD:       model_cfg.inner_kd       = val;
         cpss_pkg::REG_SERVO_CENTRE:   model_cfg.servo_centre   = val;
         cpss_pkg::REG_TWO_CAR_MODE:   model_cfg.two_car_mode   = val[0];
         cpss_pkg::REG_CASCADE_ENABLE: model_cfg.cascade_enable = val[0];
         default: ;
      endcase
   endfunction

   function automatic cpss_pkg::req_type mk_tick(logic signed [15:0] off, logic ov,
                                                 bit [5:0] flags,
                                                 logic signed [15:0] lp,
                                                 logic signed [15:0] rp,
                                                 logic signed [15:0] gy);
      cpss_pkg::req_type t;
      t.offset_sample = off;
      t.offset_valid  = ov;
      {t.meeting_enable, t.at_meeting_place, t.meeting_arrived,
       t.backing_out, t.end_line_seen, t.meeting_zone} = flags;
      t.left_count  = lp;
      t.right_count = rp;
      t.gyro_rate   = gy;
      return t;
   endfunction

   // Mostly small Q8.8 values, with full-range values and the extremes mixed in
   function automatic logic signed [15:0] rand_q88();
      int v;
      case ($urandom_range(0, 9))
         0:       v = $urandom_range(0, 1) ? 32767 : -32768;
         1, 2:    v = $urandom_range(0, 65535) - 32768;
         3, 4, 5: v = $urandom_range(0, 16384) - 8192;
         default: v = $urandom_range(0, 4096) - 2048;
      endcase
      return 16'(v);
   endfunction

   // Weighted over the modes, with a slice of pure noise on the flags
   function automatic cpss_pkg::req_type random_tick();
      cpss_pkg::req_type t;
      int                pick;
      pick = $urandom_range(0, 99);
      t.offset_sample    = rand_q88();
      t.offset_valid     = ($urandom_range(0, 9) < 7);
      t.left_count       = rand_q88();
      t.right_count      = rand_q88();
      t.gyro_rate        = rand_q88();
      t.backing_out      = ($urandom_range(0, 9) == 0);
      t.end_line_seen    = ($urandom_range(0, 2) == 0);
      t.meeting_zone     = ($urandom_range(0, 2) == 0);
      t.meeting_arrived  = 1'($urandom);
      t.meeting_enable   = 1'b0;
      t.at_meeting_place = 1'b0;
      if (pick < 8) begin
         {t.meeting_enable, t.at_meeting_place, t.meeting_arrived, t.backing_out,
          t.end_line_seen, t.meeting_zone, t.offset_valid} = 7'($urandom);
      end else if (pick >= 85) begin
         t.at_meeting_place = 1'b1;      // no mode: hold
         t.meeting_arrived  = 1'b0;
      end else if (pick >= 70) begin
         t.meeting_enable   = 1'b1;      // meeting nudge down
         t.at_meeting_place = 1'($urandom);
         t.meeting_arrived  = t.at_meeting_place ? 1'b0 : 1'($urandom);
      end else if (pick >= 55) begin
         t.at_meeting_place = 1'b1;      // arrival nudge up
         t.meeting_arrived  = 1'b1;
         t.meeting_enable   = 1'($urandom);
      end
      return t;
   endfunction

   // One register write; the caller is at a falling edge and lowers the enable
   task automatic write_reg(logic [cpss_pkg::CSR_IDX_W-1:0] idx,
                            logic [cpss_pkg::CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_regs(cpss_pkg::cfg_type c, bit poke_spare);
      write_reg(cpss_pkg::REG_OUTER_KP, c.outer_kp);
      write_reg(cpss_pkg::REG_OUTER_KD, c.outer_kd);
      write_reg(cpss_pkg::REG_INNER_KP, c.inner_kp);
      write_reg(cpss_pkg::REG_INNER_KD, c.inner_kd);
      write_reg(cpss_pkg::REG_SERVO_CENTRE, c.servo_centre);
      write_reg(cpss_pkg::REG_TWO_CAR_MODE, {15'd0, c.two_car_mode});
      write_reg(cpss_pkg::REG_CASCADE_ENABLE, {15'd0, c.cascade_enable});
      if (poke_spare) write_reg(REG_SPARE, 16'($urandom));
      csr_wr_en <= 1'b0;
      settings_seen++;
   endtask

   // Offer one tick from a falling edge, wait for its transfer, then pace the
   // sender: bursts of random length, with random gaps between them
   task automatic send_tick(cpss_pkg::req_type t, bit typed, cpss_pkg::rsp_type typed_rsp);
      cpss_pkg::rsp_type predicted;
      req_data  <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = steer_tick(t);
      awaited_outputs.push_back(typed ? typed_rsp : predicted);
      ticks_sent++;
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
      end
   endtask

   task automatic run_random(int count);
      repeat (count) send_tick(random_tick(), 1'b0, NO_RSP);
   endtask

   // Drop valid and wait for every owed result, plus a short settle
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_outputs.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Score every result transfer against the oldest owed result
   initial begin : result_checker
      cpss_pkg::rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (awaited_outputs.size() == 0) begin
               fault_count++;
               if (mismatch_reports < 10) begin
                  mismatch_reports++;
                  $display("unexpected result: pwm %0d steer %0d",
                           rsp_data.servo_pwm, rsp_data.steer_command);
               end
            end else begin
               want = awaited_outputs.pop_front();
               outputs_checked++;
               if (rsp_data.servo_pwm !== want.servo_pwm ||
                   rsp_data.steer_command !== want.steer_command) begin
                  fault_count++;
                  if (mismatch_reports < 10) begin
                     mismatch_reports++;
                     $display("result %0d: expected pwm %0d steer %0d, got pwm %0d steer %0d",
                              outputs_checked, want.servo_pwm, want.steer_command,
                              rsp_data.servo_pwm, rsp_data.steer_command);
                  end
               end
            end
         end
      end
   end

   // Receiver stall: a fresh random pattern whenever the slot counter wraps, some of them empty,
   // and one long hold-off on request so the block backs up into its input
   initial begin : stall_pattern
      int       hold_left;
      int       slot;
      bit [7:0] pattern;
      hold_left = 0;
      slot      = 0;
      pattern   = '0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = HOLD_CYCLES;
         end
         if (slot == 0) begin
            case ($urandom_range(0, 3))
               0:       pattern = '0;
               1:       pattern = 8'($urandom);
               default: pattern = 8'($urandom & $urandom & $urandom);
            endcase
         end
         slot = (slot + 1) % 24;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= pattern[slot % 8];
         end
      end
   end

   initial begin : stimulus
      cpss_pkg::cfg_type c;
      tick_row_type      tick_table [14];

      // Drive every input to a known value before the first edge
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // Register file and state as they come out of reset
      model_cfg = '{outer_kp: 16'd2074, outer_kd: 16'd6400, inner_kp: 16'd154,
                    inner_kd: 16'd205, servo_centre: 16'd1500,
                    two_car_mode: 1'b0, cascade_enable: 1'b0};
      off_now       = 0;
      off_prev      = 0;
      off_prev2     = 0;
      held_steer    = 0;
      rate_err_last = 0;

      tick_table = '{
         // fresh from reset with zero offset: straight ahead at the centre value
         '{mk_tick(16'sd0, 1'b1, NO_FLAGS, 16'sd0, 16'sd0, 16'sd0),
           1'b1, '{16'd1418 + 16'd82, 8'sd0}},
         // full positive offset pins the outer command at its upper clamp
         '{mk_tick(16'sh7FFF, 1'b1, NO_FLAGS, 16'sd5, 16'sd5, 16'sd0),
           1'b1, '{16'd1418, 8'sd82}},
         // no mode applies: hold the previous command
         '{mk_tick(16'sd0, 1'b0, F_PLACE, 16'sd5, 16'sd5, 16'sd0),
           1'b1, '{16'd1418, 8'sd82}},
         // full negative offset, derivative across the whole range
         '{mk_tick(16'sh8000, 1'b1, NO_FLAGS, 16'sd5, 16'sd5, 16'sd0), 1'b0, NO_RSP},
         // arrival nudge saturates at the top of Q8.8
         '{mk_tick(16'sh7FFF, 1'b1, F_PLACE | F_ARRIVED, 16'sd100, 16'sd100, 16'sd0),
           1'b0, NO_RSP},
         // meeting nudge saturates at the bottom
         '{mk_tick(16'sh8000, 1'b1, F_MEET, 16'sd100, 16'sd100, 16'sd0), 1'b0, NO_RSP},
         // meeting at the place but not arrived: still the meeting nudge
         '{mk_tick(16'sd512, 1'b1, F_MEET | F_PLACE, 16'sd5, 16'sd5, 16'sd0), 1'b0, NO_RSP},
         // arrival takes priority over meeting; gyro at its top
         '{mk_tick(16'sd512, 1'b1, F_MEET | F_PLACE | F_ARRIVED, 16'sd5, 16'sd5, 16'sh7FFF),
           1'b0, NO_RSP},
         // arrived flag alone is plain PD; reversing inverts; gyro at its bottom
         '{mk_tick(16'sd3000, 1'b1, F_ARRIVED | F_BACK, 16'sd5, 16'sd5, 16'sh8000),
           1'b0, NO_RSP},
         // both wheels reversed inside the meeting zone
         '{mk_tick(-16'sd700, 1'b1, F_ZONE, -16'sd1, -16'sd1, 16'sd400), 1'b0, NO_RSP},
         // both wheels reversed at the end line: inverts only in two-car mode
         '{mk_tick(16'sd900, 1'b1, F_ENDLINE, 16'sh8000, 16'sh8000, -16'sd400),
           1'b0, NO_RSP},
         // one wheel reversed in the zone: no inversion
         '{mk_tick(16'sd900, 1'b1, F_ZONE, -16'sd5, 16'sd7, 16'sd0), 1'b0, NO_RSP},
         // zero count is not reversed; sample ignored without its valid flag
         '{mk_tick(16'sh1234, 1'b0, F_ZONE, 16'sd0, -16'sd3, 16'sd0), 1'b0, NO_RSP},
         // held command under reversing and the zone rule together
         '{mk_tick(16'sd0, 1'b0, F_PLACE | F_BACK | F_ZONE, -16'sd9, -16'sd9, 16'sd0),
           1'b0, NO_RSP}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table at reset settings
      foreach (tick_table[i]) begin
         send_tick(tick_table[i].tick, tick_table[i].typed, tick_table[i].rsp);
      end
      drain();

      // Same table again with the inner loop and the two-car rule on, then random
      // ticks; part-way through, hold the output off for a long stretch
      c = model_cfg;
      c.two_car_mode   = 1'b1;
      c.cascade_enable = 1'b1;
      program_regs(c, 1'b0);
      foreach (tick_table[i]) send_tick(tick_table[i].tick, 1'b0, NO_RSP);
      run_random(20);
      long_hold_due = 1'b1;
      run_random(80);
      drain();

      // All gains at zero, lowest centre
      c = '{outer_kp: 16'd0, outer_kd: 16'd0, inner_kp: 16'd0, inner_kd: 16'd0,
            servo_centre: 16'd82, two_car_mode: 1'b0, cascade_enable: 1'b1};
      program_regs(c, 1'b1);
      run_random(100);
      drain();

      // All gains at full scale, highest centre
      c = '{outer_kp: 16'hFFFF, outer_kd: 16'hFFFF, inner_kp: 16'hFFFF, inner_kd: 16'hFFFF,
            servo_centre: 16'd65453, two_car_mode: 1'b1, cascade_enable: 1'b1};
      program_regs(c, 1'b0);
      run_random(100);
      drain();

      // Random gains, outer loop only
      c = '{outer_kp: 16'($urandom), outer_kd: 16'($urandom), inner_kp: 16'($urandom),
            inner_kd: 16'($urandom), servo_centre: 16'($urandom_range(82, 65453)),
            two_car_mode: 1'b1, cascade_enable: 1'b0};
      program_regs(c, 1'b1);
      run_random(100);
      drain();

      // Everything random
      c = '{outer_kp: 16'($urandom), outer_kd: 16'($urandom), inner_kp: 16'($urandom),
            inner_kd: 16'($urandom), servo_centre: 16'($urandom_range(82, 65453)),
            two_car_mode: 1'($urandom), cascade_enable: 1'($urandom)};
      program_regs(c, 1'b1);
      run_random(120);
      drain();

      // Let any stray result show up before closing the books
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_outputs.size() != 0) begin
         $display("%0d results never arrived", awaited_outputs.size());
         fault_count += awaited_outputs.size();
      end

      $display("run covered %0d ticks and %0d checked results over %0d register settings,",
               ticks_sent, outputs_checked, settings_seen + 1);
      $display("with random sender gaps, receiver stalls and one %0d-cycle output hold-off",
               HOLD_CYCLES);
      if (fault_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
